>>> sv/fcse_pkg.sv
// Shared types and constants for the fixed-capacity sequence engine.
`default_nettype none
package fcse_pkg;

   // Port widths of the request and response words
   localparam int REQ_TYPE_W = 3;
   localparam int POS_W      = 9;
   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = 9;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [REQ_TYPE_W-1:0] {
      OP_INSERT_AT     = 3'd0,
      OP_INSERT_SORTED = 3'd1,
      OP_ERASE_AT      = 3'd2,
      OP_REMOVE_ALL    = 3'd3,
      OP_GET           = 3'd4,
      OP_SET           = 3'd5,
      OP_FIND          = 3'd6,
      OP_NONE          = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT_UP,
      ST_SHIFT_DN,
      ST_GET
   } state_type;

   // Head of the command queue as seen by the back end
   typedef struct packed {
      logic   valid;
      op_type op;
   } cmd_ctl_type;

endpackage
`default_nettype wire

>>> sv/fcse_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module fcse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> sv/fcse_front.sv
// Front end: takes request words, decodes the opcode, queues commands.
`default_nettype none
module fcse_front #(
   parameter int WORD_BITS = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [fcse_pkg::REQ_TYPE_W-1:0]       req_type,
   input  wire logic [fcse_pkg::POS_W-1:0]            req_position,
   input  wire logic [fcse_pkg::VALUE_W-1:0]          req_value,
   output fcse_pkg::cmd_ctl_type                      cmd_ctl,
   output logic      [fcse_pkg::POS_W-1:0]            cmd_pos,
   output logic      [WORD_BITS-1:0]                  cmd_val,
   input  wire logic                                  cmd_pop
);

   fcse_pkg::op_type               q_op_ff  [fcse_pkg::QUEUE_DEPTH];
   logic [fcse_pkg::POS_W-1:0]     q_pos_ff [fcse_pkg::QUEUE_DEPTH];
   logic [WORD_BITS-1:0]           q_val_ff [fcse_pkg::QUEUE_DEPTH];
   logic [fcse_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [fcse_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [fcse_pkg::QCNT_W-1:0]    q_cnt_ff, q_cnt_in;
   fcse_pkg::op_type               dec_op;
   logic                           push;
   logic                           pop;

   // every 3-bit code maps onto an opcode; the unused one is OP_NONE
   always_comb begin
      dec_op = fcse_pkg::op_type'(req_type);
   end

   assign busy  = (q_cnt_ff == fcse_pkg::QCNT_W'(fcse_pkg::QUEUE_DEPTH));
   assign push  = start && !busy;
   assign pop   = cmd_pop && (q_cnt_ff != '0);

   assign cmd_ctl.valid = (q_cnt_ff != '0);
   assign cmd_ctl.op    = q_op_ff[rd_ptr_ff];
   assign cmd_pos       = q_pos_ff[rd_ptr_ff];
   assign cmd_val       = q_val_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      q_cnt_in  = q_cnt_ff;
      if (push && !pop) begin
         q_cnt_in = q_cnt_ff + 1'b1;
      end else if (pop && !push) begin
         q_cnt_in = q_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         q_cnt_ff  <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_op_ff[wr_ptr_ff]  <= dec_op;
         q_pos_ff[wr_ptr_ff] <= req_position;
         q_val_ff[wr_ptr_ff] <= WORD_BITS'(req_value);
      end
   end

   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= fcse_pkg::QCNT_W'(fcse_pkg::QUEUE_DEPTH))
      else $error("command queue over depth");

   a_q_ptrs: assert property (@(posedge clock) disable iff (reset)
      (q_cnt_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

   a_q_push_full: assert property (@(posedge clock) disable iff (reset)
      (busy && !pop) |=> (q_cnt_ff == fcse_pkg::QCNT_W'(fcse_pkg::QUEUE_DEPTH)))
      else $error("full queue lost an entry");

endmodule
`default_nettype wire

>>> sv/fcse_back.sv
// Back end: list sequencer that scans and shifts the item RAM.
`default_nettype none
module fcse_back #(
   parameter int CAPACITY  = 256,
   parameter int WORD_BITS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire fcse_pkg::cmd_ctl_type             cmd_ctl,
   input  wire logic [fcse_pkg::POS_W-1:0]        cmd_pos,
   input  wire logic [WORD_BITS-1:0]              cmd_val,
   output logic                                   cmd_pop,
   output logic                                   rsp_strobe,
   output logic                                   rsp_ok,
   output logic      [fcse_pkg::VALUE_W-1:0]      rsp_read_value,
   output logic      [fcse_pkg::COUNT_W-1:0]      rsp_index_or_count,
   output logic      [fcse_pkg::COUNT_W-1:0]      rsp_item_count,
   output logic                                   rsp_is_empty
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int AW    = $clog2(CAPACITY);
   localparam int CMP_W = (CNT_W > fcse_pkg::POS_W) ? CNT_W : fcse_pkg::POS_W;

   fcse_pkg::state_type  state_ff, state_in;
   fcse_pkg::op_type     op_ff, op_in;
   logic [WORD_BITS-1:0] val_ff, val_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     ptr_ff, ptr_in;
   logic [CNT_W-1:0]     tgt_ff, tgt_in;
   logic [CNT_W-1:0]     wr_idx_ff, wr_idx_in;
   logic                 pend_ff, pend_in;
   logic [CNT_W-1:0]     pend_addr_ff, pend_addr_in;

   logic                          strobe_ff;
   logic                          ok_ff;
   logic [fcse_pkg::VALUE_W-1:0]  rd_ff;
   logic [fcse_pkg::COUNT_W-1:0]  idx_ff;
   logic [fcse_pkg::COUNT_W-1:0]  count_ff;
   logic                          empty_ff;

   logic                          done;
   logic                          ok_v;
   logic [fcse_pkg::VALUE_W-1:0]  rd_v;
   logic [CNT_W-1:0]              idx_v;

   logic                 ram_wr_en, ram_rd_en;
   logic [AW-1:0]        ram_wr_addr, ram_rd_addr;
   logic [WORD_BITS-1:0] ram_wr_data, ram_rd_data;

   logic [CMP_W-1:0]     pos_ext, cnt_ext;
   logic                 full;
   logic                 hit_ge, hit_eq;

   fcse_ram #(.WIDTH(WORD_BITS), .DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign pos_ext = CMP_W'(cmd_pos);
   assign cnt_ext = CMP_W'(cnt_ff);
   assign full    = (cnt_ff == CNT_W'(CAPACITY));
   assign hit_ge  = (ram_rd_data >= val_ff);
   assign hit_eq  = (ram_rd_data == val_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      val_in       = val_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      tgt_in       = tgt_ff;
      wr_idx_in    = wr_idx_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      cmd_pop      = 1'b0;
      done         = 1'b0;
      ok_v         = 1'b0;
      rd_v         = '0;
      idx_v        = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = val_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      unique case (state_ff)
         fcse_pkg::ST_IDLE: begin
            if (cmd_ctl.valid) begin
               cmd_pop = 1'b1;
               op_in   = cmd_ctl.op;
               val_in  = cmd_val;
               unique case (cmd_ctl.op)
                  fcse_pkg::OP_INSERT_AT: begin
                     if (!full && pos_ext <= cnt_ext) begin
                        tgt_in   = CNT_W'(cmd_pos);
                        ptr_in   = cnt_ff;
                        state_in = fcse_pkg::ST_SHIFT_UP;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  fcse_pkg::OP_INSERT_SORTED: begin
                     if (!full) begin
                        ptr_in   = '0;
                        state_in = fcse_pkg::ST_SCAN;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  fcse_pkg::OP_ERASE_AT: begin
                     if (pos_ext < cnt_ext) begin
                        ptr_in   = CNT_W'(cmd_pos) + CNT_W'(1);
                        state_in = fcse_pkg::ST_SHIFT_DN;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  fcse_pkg::OP_REMOVE_ALL: begin
                     ptr_in    = '0;
                     wr_idx_in = '0;
                     state_in  = fcse_pkg::ST_SCAN;
                  end
                  fcse_pkg::OP_GET: begin
                     if (pos_ext < cnt_ext) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(cmd_pos);
                        state_in    = fcse_pkg::ST_GET;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  fcse_pkg::OP_SET: begin
                     done = 1'b1;
                     if (pos_ext < cnt_ext) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = AW'(cmd_pos);
                        ram_wr_data = cmd_val;
                        ok_v        = 1'b1;
                     end
                  end
                  fcse_pkg::OP_FIND: begin
                     ptr_in   = '0;
                     state_in = fcse_pkg::ST_SCAN;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end

         fcse_pkg::ST_SCAN: begin
            // one read issued per cycle, compared the cycle after
            if (ptr_ff < cnt_ff) begin
               ram_rd_en    = 1'b1;
               ram_rd_addr  = AW'(ptr_ff);
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff;
               ptr_in       = ptr_ff + CNT_W'(1);
            end
            priority case (op_ff)
               fcse_pkg::OP_INSERT_SORTED: begin
                  if (pend_ff && hit_ge) begin
                     tgt_in   = pend_addr_ff;
                     ptr_in   = cnt_ff;
                     pend_in  = 1'b0;
                     state_in = fcse_pkg::ST_SHIFT_UP;
                  end else if (!pend_ff && ptr_ff == cnt_ff) begin
                     tgt_in   = cnt_ff;
                     ptr_in   = cnt_ff;
                     state_in = fcse_pkg::ST_SHIFT_UP;
                  end
               end
               fcse_pkg::OP_FIND: begin
                  if (pend_ff && hit_eq) begin
                     done     = 1'b1;
                     ok_v     = 1'b1;
                     idx_v    = pend_addr_ff;
                     pend_in  = 1'b0;
                     state_in = fcse_pkg::ST_IDLE;
                  end else if (!pend_ff && ptr_ff == cnt_ff) begin
                     done     = 1'b1;
                     state_in = fcse_pkg::ST_IDLE;
                  end
               end
               default: begin
                  // remove all: compact kept items down to the write index
                  if (pend_ff && !hit_eq) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = AW'(wr_idx_ff);
                     ram_wr_data = ram_rd_data;
                     wr_idx_in   = wr_idx_ff + CNT_W'(1);
                  end
                  if (!pend_ff && ptr_ff == cnt_ff) begin
                     done     = 1'b1;
                     ok_v     = 1'b1;
                     idx_v    = cnt_ff - wr_idx_ff;
                     cnt_in   = wr_idx_ff;
                     state_in = fcse_pkg::ST_IDLE;
                  end
               end
            endcase
         end

         fcse_pkg::ST_SHIFT_UP: begin
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = AW'(pend_addr_ff);
               ram_wr_data = ram_rd_data;
            end
            if (ptr_ff > tgt_ff) begin
               ram_rd_en    = 1'b1;
               ram_rd_addr  = AW'(ptr_ff - CNT_W'(1));
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff;
               ptr_in       = ptr_ff - CNT_W'(1);
            end else if (!pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = AW'(tgt_ff);
               ram_wr_data = val_ff;
               cnt_in      = cnt_ff + CNT_W'(1);
               done        = 1'b1;
               ok_v        = 1'b1;
               idx_v       = (op_ff == fcse_pkg::OP_INSERT_SORTED) ? tgt_ff : '0;
               state_in    = fcse_pkg::ST_IDLE;
            end
         end

         fcse_pkg::ST_SHIFT_DN: begin
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = AW'(pend_addr_ff);
               ram_wr_data = ram_rd_data;
            end
            if (ptr_ff < cnt_ff) begin
               ram_rd_en    = 1'b1;
               ram_rd_addr  = AW'(ptr_ff);
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff - CNT_W'(1);
               ptr_in       = ptr_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               cnt_in   = cnt_ff - CNT_W'(1);
               done     = 1'b1;
               ok_v     = 1'b1;
               state_in = fcse_pkg::ST_IDLE;
            end
         end

         fcse_pkg::ST_GET: begin
            done     = 1'b1;
            ok_v     = 1'b1;
            rd_v     = fcse_pkg::VALUE_W'(ram_rd_data);
            state_in = fcse_pkg::ST_IDLE;
         end

         default: begin
            state_in = fcse_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fcse_pkg::ST_IDLE;
         cnt_ff    <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         pend_ff   <= pend_in;
         strobe_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      val_ff       <= val_in;
      ptr_ff       <= ptr_in;
      tgt_ff       <= tgt_in;
      wr_idx_ff    <= wr_idx_in;
      pend_addr_ff <= pend_addr_in;
      if (done) begin
         ok_ff    <= ok_v;
         rd_ff    <= rd_v;
         idx_ff   <= fcse_pkg::COUNT_W'(idx_v);
         count_ff <= fcse_pkg::COUNT_W'(cnt_in);
         empty_ff <= (cnt_in == '0);
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_ok             = ok_ff;
   assign rsp_read_value     = rd_ff;
   assign rsp_index_or_count = idx_ff;
   assign rsp_item_count     = count_ff;
   assign rsp_is_empty       = empty_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("item count above capacity");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (state_ff == fcse_pkg::ST_IDLE))
      else $error("response while sequencer still busy");

   a_shift_up_ptr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fcse_pkg::ST_SHIFT_UP) |-> (ptr_ff >= tgt_ff))
      else $error("shift-up pointer passed insertion point");

   a_pend_state: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == fcse_pkg::ST_SCAN || state_ff == fcse_pkg::ST_SHIFT_UP
                   || state_ff == fcse_pkg::ST_SHIFT_DN))
      else $error("pending read outside a walk");

endmodule
`default_nettype wire

>>> sv/fixed_capacity_sequence_engine_unit.sv
// Top level of the fixed-capacity ordered word list engine.
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   ----------------------------
//  request   req_type, req_position, req_value       taken when start & !busy
//  response  rsp_ok, rsp_read_value,                 valid for one cycle while
//            rsp_index_or_count, rsp_item_count,     rsp_strobe is high
//            rsp_is_empty
//
// Ops: set and rejects answer straight from idle, get through a read state. Walks move
//   one RAM entry a cycle (one read, one write port): insert_at, erase_at, remove_all
//   and find, and insert_sorted (scan to the hit, then shift the tail).
// Reset: synchronous, clears the count and the queue; the item RAM is not cleared.
// Stalls: a two-entry command queue lets requests land while a walk runs;
//   busy rises only when the queue is full. Responses cannot be held off.
`default_nettype none
module fixed_capacity_sequence_engine_unit #(
   parameter int CAPACITY  = 256,
   parameter int WORD_BITS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [fcse_pkg::REQ_TYPE_W-1:0]   req_type,
   input  wire logic [fcse_pkg::POS_W-1:0]        req_position,
   input  wire logic [fcse_pkg::VALUE_W-1:0]      req_value,
   output logic                                   rsp_strobe,
   output logic                                   rsp_ok,
   output logic      [fcse_pkg::VALUE_W-1:0]      rsp_read_value,
   output logic      [fcse_pkg::COUNT_W-1:0]      rsp_index_or_count,
   output logic      [fcse_pkg::COUNT_W-1:0]      rsp_item_count,
   output logic                                   rsp_is_empty
);

   // decoded command at the head of the queue
   fcse_pkg::cmd_ctl_type       cmd_ctl;
   logic [fcse_pkg::POS_W-1:0]  cmd_pos;
   logic [WORD_BITS-1:0]        cmd_val;   // already cut to the item width
   logic                        cmd_pop;

   // front: decode and queue
   fcse_front #(.WORD_BITS(WORD_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_type     (req_type),
      .req_position (req_position),
      .req_value    (req_value),
      .cmd_ctl      (cmd_ctl),
      .cmd_pos      (cmd_pos),
      .cmd_val      (cmd_val),
      .cmd_pop      (cmd_pop)
   );

   // back: count register, item RAM and the walk sequencer
   fcse_back #(.CAPACITY(CAPACITY), .WORD_BITS(WORD_BITS)) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_ctl            (cmd_ctl),
      .cmd_pos            (cmd_pos),
      .cmd_val            (cmd_val),
      .cmd_pop            (cmd_pop),
      .rsp_strobe         (rsp_strobe),
      .rsp_ok             (rsp_ok),
      .rsp_read_value     (rsp_read_value),
      .rsp_index_or_count (rsp_index_or_count),
      .rsp_item_count     (rsp_item_count),
      .rsp_is_empty       (rsp_is_empty)
   );

endmodule
`default_nettype wire

>>> dv/fcse_list_checker.sv
// Response checker for the sequence engine: mirrors the list and compares every response word.
module fcse_list_checker #(
   parameter int CAPACITY = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            busy,
   input  wire logic [fcse_pkg::REQ_TYPE_W-1:0] req_type,
   input  wire logic [fcse_pkg::POS_W-1:0]      req_position,
   input  wire logic [fcse_pkg::VALUE_W-1:0]    req_value,
   input  wire logic                            rsp_strobe,
   input  wire logic                            rsp_ok,
   input  wire logic [fcse_pkg::VALUE_W-1:0]    rsp_read_value,
   input  wire logic [fcse_pkg::COUNT_W-1:0]    rsp_index_or_count,
   input  wire logic [fcse_pkg::COUNT_W-1:0]    rsp_item_count,
   input  wire logic                            rsp_is_empty,
   output int                                   fail_count,
   output int                                   outstanding,
   output int                                   held_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                         ok;
      logic [fcse_pkg::VALUE_W-1:0] read_value;
      logic [fcse_pkg::COUNT_W-1:0] index_or_count;
      logic [fcse_pkg::COUNT_W-1:0] item_count;
      logic                         is_empty;
   } rsp_word_type;

   logic [fcse_pkg::VALUE_W-1:0] list_mem [CAPACITY];
   int                           list_len;
   rsp_word_type                 pending_rsp [$];

   // Applies one request word to the mirrored list and returns its response.
   function automatic rsp_word_type apply_request(
      input fcse_pkg::op_type             op,
      input logic [fcse_pkg::POS_W-1:0]   pos,
      input logic [fcse_pkg::VALUE_W-1:0] val);
      rsp_word_type r;
      int           p;
      int           k;
      int           w;
      r = '0;
      p = int'(pos);
      case (op)
         fcse_pkg::OP_INSERT_AT: begin
            if (list_len < CAPACITY && p <= list_len) begin
               for (k = list_len; k > p; k--) list_mem[k] = list_mem[k-1];
               list_mem[p] = val;
               list_len++;
               r.ok = 1'b1;
            end
         end
         fcse_pkg::OP_INSERT_SORTED: begin
            if (list_len < CAPACITY) begin
               p = list_len;
               for (k = 0; k < list_len; k++) begin
                  if (list_mem[k] >= val) begin
                     p = k;
                     break;
                  end
               end
               for (k = list_len; k > p; k--) list_mem[k] = list_mem[k-1];
               list_mem[p] = val;
               list_len++;
               r.ok = 1'b1;
               r.index_or_count = fcse_pkg::COUNT_W'(p);
            end
         end
         fcse_pkg::OP_ERASE_AT: begin
            if (p < list_len) begin
               for (k = p; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
               list_len--;
               r.ok = 1'b1;
            end
         end
         fcse_pkg::OP_REMOVE_ALL: begin
            w = 0;
            for (k = 0; k < list_len; k++) begin
               if (list_mem[k] != val) begin
                  list_mem[w] = list_mem[k];
                  w++;
               end
            end
            r.index_or_count = fcse_pkg::COUNT_W'(list_len - w);
            list_len = w;
            r.ok = 1'b1;
         end
         fcse_pkg::OP_GET: begin
            if (p < list_len) begin
               r.read_value = list_mem[p];
               r.ok = 1'b1;
            end
         end
         fcse_pkg::OP_SET: begin
            if (p < list_len) begin
               list_mem[p] = val;
               r.ok = 1'b1;
            end
         end
         fcse_pkg::OP_FIND: begin
            for (k = 0; k < list_len; k++) begin
               if (list_mem[k] == val) begin
                  r.ok = 1'b1;
                  r.index_or_count = fcse_pkg::COUNT_W'(k);
                  break;
               end
            end
         end
         default: begin
         end
      endcase
      r.item_count = fcse_pkg::COUNT_W'(list_len);
      r.is_empty   = (list_len == 0);
      return r;
   endfunction

   // Inputs and outputs are read before the edge's updates land.
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         list_len   = 0;
         fail_count = 0;
         pending_rsp.delete();
      end else begin
         // response first: it always belongs to an older word
         if (rsp_strobe) begin
            if (pending_rsp.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response: ok=%0d rd=%h idx=%0d cnt=%0d empty=%0d",
                           rsp_ok, rsp_read_value, rsp_index_or_count, rsp_item_count,
                           rsp_is_empty);
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_ok !== want.ok || rsp_read_value !== want.read_value ||
                   rsp_index_or_count !== want.index_or_count ||
                   rsp_item_count !== want.item_count || rsp_is_empty !== want.is_empty) begin
                  if (fail_count < 10) begin
                     $write("response mismatch: exp ok=%0d rd=%h idx=%0d cnt=%0d empty=%0d",
                            want.ok, want.read_value, want.index_or_count, want.item_count,
                            want.is_empty);
                     $display(" / got ok=%0d rd=%h idx=%0d cnt=%0d empty=%0d",
                              rsp_ok, rsp_read_value, rsp_index_or_count,
                              rsp_item_count, rsp_is_empty);
                  end
                  fail_count++;
               end
            end
         end
         if (start && !busy)
            pending_rsp.push_back(apply_request(fcse_pkg::op_type'(req_type),
                                                req_position, req_value));
      end
      outstanding = pending_rsp.size();
      held_count  = list_len;
   end

endmodule

>>> dv/tb.sv
// Testbench top: drives request words into the sequence engine and gives the verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY     = 256;
   localparam int NUM_PHASES   = 11;
   localparam int STALL_LIMIT  = 4000;  // quiet cycles
   localparam int DRAIN_CYCLES = 300;   // longest walk plus margin

   logic                            clock        = 1'b0;
   logic                            reset        = 1'b1;
   logic                            start        = 1'b0;
   logic                            busy;
   logic [fcse_pkg::REQ_TYPE_W-1:0] req_type     = '0;
   logic [fcse_pkg::POS_W-1:0]      req_position = '0;
   logic [fcse_pkg::VALUE_W-1:0]    req_value    = '0;
   logic                            rsp_strobe;
   logic                            rsp_ok;
   logic [fcse_pkg::VALUE_W-1:0]    rsp_read_value;
   logic [fcse_pkg::COUNT_W-1:0]    rsp_index_or_count;
   logic [fcse_pkg::COUNT_W-1:0]    rsp_item_count;
   logic                            rsp_is_empty;

   int                              fail_count;
   int                              outstanding;
   int                              held_count;

   // Per-phase value pool so find and remove_all actually hit stored items.
   logic [fcse_pkg::VALUE_W-1:0]    value_pool [6];

   always #5 clock = ~clock;

   fixed_capacity_sequence_engine_unit #(
      .CAPACITY  (CAPACITY),
      .WORD_BITS (32)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_ok             (rsp_ok),
      .rsp_read_value     (rsp_read_value),
      .rsp_index_or_count (rsp_index_or_count),
      .rsp_item_count     (rsp_item_count),
      .rsp_is_empty       (rsp_is_empty)
   );

   fcse_list_checker #(
      .CAPACITY (CAPACITY)
   ) list_chk (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_ok             (rsp_ok),
      .rsp_read_value     (rsp_read_value),
      .rsp_index_or_count (rsp_index_or_count),
      .rsp_item_count     (rsp_item_count),
      .rsp_is_empty       (rsp_is_empty),
      .fail_count         (fail_count),
      .outstanding        (outstanding),
      .held_count         (held_count)
   );

   // Fill level each random phase steers toward. Small lists dominate since
   // walks move one stored entry per cycle; one phase fills the store and one
   // sits at full so the full-store rejects and the longest walks get hit.
   function automatic int phase_target(input int ph);
      case (ph)
         0:       return 6;
         1:       return 16;
         2:       return 0;
         3:       return 48;
         4:       return CAPACITY;
         5:       return CAPACITY;
         6:       return 200;
         7:       return 3;
         8:       return 10;
         9:       return 1;
         default: return 30;
      endcase
   endfunction

   function automatic int phase_length(input int ph);
      case (ph)
         0:       return 140;
         1:       return 140;
         2:       return 40;
         3:       return 140;
         4:       return 400;
         5:       return 120;
         6:       return 100;
         7:       return 120;
         8:       return 140;
         9:       return 60;
         default: return 130;  // final phase, never idles
      endcase
   endfunction

   // Percent chance of an idle burst ahead of a word; every third phase runs flat out.
   function automatic int idle_pct(input int ph);
      if (ph == NUM_PHASES - 1 || ph % 3 == 1) return 0;
      return 25;
   endfunction

   // Op mix leans toward moving the fill level to the phase target.
   function automatic fcse_pkg::op_type pick_op(input int cur, input int tgt);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return fcse_pkg::OP_NONE;  // unused code: no change, ok=0
      if (cur < tgt) begin
         // growing: no erase or remove_all, else a large pool hit stalls the fill
         if (r < 55) return fcse_pkg::OP_INSERT_AT;
         if (r < 85) return fcse_pkg::OP_INSERT_SORTED;
         if (r < 90) return fcse_pkg::OP_GET;
         if (r < 95) return fcse_pkg::OP_FIND;
         return fcse_pkg::OP_SET;
      end
      if (cur > tgt) begin
         if (r < 45) return fcse_pkg::OP_ERASE_AT;
         if (r < 52) return fcse_pkg::OP_REMOVE_ALL;
      end
      return fcse_pkg::op_type'(fcse_pkg::REQ_TYPE_W'($urandom_range(0, 6)));
   endfunction

   // Mostly in-range positions, with the boundary and out-of-range cases mixed in.
   function automatic logic [fcse_pkg::POS_W-1:0] pick_position(input fcse_pkg::op_type op,
                                                                input int cur);
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return fcse_pkg::POS_W'($urandom_range(0, CAPACITY));
      if (r < 18) return fcse_pkg::POS_W'(cur);  // append for insert_at, else one past the end
      if (op == fcse_pkg::OP_INSERT_AT) return fcse_pkg::POS_W'($urandom_range(0, cur));
      if (cur == 0) return '0;
      return fcse_pkg::POS_W'($urandom_range(0, cur - 1));
   endfunction

   function automatic logic [fcse_pkg::VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return value_pool[$urandom_range(0, 5)];
      if (r == 6) return ($urandom_range(0, 1) == 0) ? '0 : '1;
      return fcse_pkg::VALUE_W'($urandom);
   endfunction

   // Present one word from a falling edge and hold it until taken. start stays
   // high on return, so back-to-back words never lower and raise it in one step.
   task automatic issue(input fcse_pkg::op_type op, input logic [fcse_pkg::POS_W-1:0] pos,
                        input logic [fcse_pkg::VALUE_W-1:0] val);
      start        <= 1'b1;
      req_type     <= op;
      req_position <= pos;
      req_value    <= val;
      // busy is read right at the edge, before the block's own updates land
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Sender idle burst; junk on the request fields must be ignored.
   task automatic idle_gap(input int n);
      start        <= 1'b0;
      req_type     <= fcse_pkg::REQ_TYPE_W'($urandom);
      req_position <= fcse_pkg::POS_W'($urandom);
      req_value    <= fcse_pkg::VALUE_W'($urandom);
      repeat (n) @(negedge clock);
   endtask

   // Watchdog: ends the run once nothing has moved on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe) quiet = 0;
         else quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int cur;
      fcse_pkg::op_type op;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed: every op but insert_sorted on an empty list, including the unused code
      issue(fcse_pkg::OP_GET, 9'd0, 32'h0);
      issue(fcse_pkg::OP_ERASE_AT, 9'd0, 32'h0);
      issue(fcse_pkg::OP_SET, 9'd0, 32'h1234_5678);
      issue(fcse_pkg::OP_FIND, 9'd0, 32'h0);
      issue(fcse_pkg::OP_REMOVE_ALL, 9'd0, 32'h0);  // ok with nothing removed
      issue(fcse_pkg::OP_NONE, 9'd0, 32'hFFFF_FFFF);
      issue(fcse_pkg::OP_INSERT_AT, 9'd1, 32'h1);   // past the end
      // Build a short list: head, append, middle
      issue(fcse_pkg::OP_INSERT_AT, 9'd0, 32'h0000_0000);
      issue(fcse_pkg::OP_INSERT_AT, 9'd1, 32'hFFFF_FFFF);
      issue(fcse_pkg::OP_INSERT_AT, 9'd1, 32'h5555_5555);
      // Sorted inserts: middle, equal to head, equal to tail
      issue(fcse_pkg::OP_INSERT_SORTED, 9'd0, 32'hAAAA_AAAA);
      issue(fcse_pkg::OP_INSERT_SORTED, 9'd0, 32'h0000_0000);
      issue(fcse_pkg::OP_INSERT_SORTED, 9'd0, 32'hFFFF_FFFF);
      issue(fcse_pkg::OP_GET, 9'd2, 32'h0);
      issue(fcse_pkg::OP_GET, 9'd256, 32'h0);       // top position bit set
      issue(fcse_pkg::OP_SET, 9'd6, 32'h0);         // one past the end
      issue(fcse_pkg::OP_SET, 9'd0, 32'hFFFF_FFFF);
      issue(fcse_pkg::OP_FIND, 9'd0, 32'hFFFF_FFFF);
      issue(fcse_pkg::OP_FIND, 9'd0, 32'h1357_9BDF); // miss
      issue(fcse_pkg::OP_INSERT_SORTED, 9'd0, 32'h7FFF_FFFF);
      issue(fcse_pkg::OP_ERASE_AT, 9'd6, 32'h0);    // last item
      issue(fcse_pkg::OP_ERASE_AT, 9'd0, 32'h0);
      issue(fcse_pkg::OP_REMOVE_ALL, 9'd0, 32'hFFFF_FFFF);
      issue(fcse_pkg::OP_GET, 9'd0, 32'h0);

      // Random phases, each steering the fill level toward its target
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         for (int j = 0; j < 6; j++) value_pool[j] = fcse_pkg::VALUE_W'($urandom);
         for (int i = 0; i < phase_length(ph); i++) begin
            if ($urandom_range(0, 99) < idle_pct(ph)) idle_gap($urandom_range(1, 8));
            cur = held_count;  // checker's list length, current at the falling edge
            op  = pick_op(cur, phase_target(ph));
            issue(op, pick_position(op, cur), pick_value());
         end
      end
      start <= 1'b0;

      // Wait out the responses still owed, then a quiet stretch for strays;
      // the watchdog bounds both waits.
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && outstanding == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
